// ===== hw/rtl/ibfr_pkg.sv =====
// Shared types, constants and helpers for the IMU burst frame receiver.
package ibfr_pkg;

    localparam int FRAME_MAX       = 34;
    localparam int NARROW_LEN      = 22;
    localparam int WIDE_LEN        = 34;
    localparam int POS_W           = 6;
    localparam int TEMP_CNT_W      = 7;
    localparam int TEMP_SUM_W      = 23;
    localparam int TEMP_WINDOW_DEF = 100;
    localparam int OUT_DATA_W      = 256;

    typedef logic [FRAME_MAX-1:0][7:0] t_frame;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_BAD = 2'd1,
        STAT_DUP = 2'd2
    } t_status;

    typedef struct packed {
        t_status                 status;
        logic                    lost_sample;
        logic [15:0]             sample_counter;
        logic [15:0]             diag_word;
        logic signed [31:0]      rot_x;
        logic signed [31:0]      rot_y;
        logic signed [31:0]      rot_z;
        logic signed [31:0]      lin_x;
        logic signed [31:0]      lin_y;
        logic signed [31:0]      lin_z;
        logic                    temp_ready;
        logic signed [TEMP_SUM_W-1:0] temp_window_sum;
    } t_result;

    // big-endian word starting at byte p
    function automatic logic [15:0] word16(input t_frame f, input int p);
        word16 = {f[p], f[p+1]};
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        if (v == 32'sh8000_0000) begin
            neg_sat = 32'sh7fff_ffff;
        end else begin
            neg_sat = -v;
        end
    endfunction

endpackage

// ===== hw/rtl/imu_burst_frame_receiver_unit.sv =====
// Top level of the IMU burst frame receiver: config register, stream ports, result register.
//
//  channel   direction  handshake                    payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata rx_byte, tuser frame_start
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata result fields, tuser status
//  cfg       in         i_cfg_valid/o_cfg_ready          burst_wide
//
// One byte item per cycle while input is not stalled. The last byte of a frame is registered
// with the frame, decoded combinationally, and the result lands in the result register when it is free.
// Synchronous active-low reset; no clearing pass.
// If a decoded frame waits on a full, stalled result register, input stalls until it moves.
module imu_burst_frame_receiver_unit
    import ibfr_pkg::*;
#(
    parameter int TEMP_WINDOW = TEMP_WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // rx_byte
    input  logic                  i_s_axis_tuser,   // frame_start
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // lost_sample, sample_counter, diag_word, rot_x, rot_y, rot_z,
    // lin_x, lin_y, lin_z, temp_ready, temp_window_sum, zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]            o_m_axis_tuser,   // status
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_data        // burst_wide
);

    logic                  r_burst_wide;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [1:0]            r_out_user;

    t_frame     frame;
    logic [7:0] sum;
    logic       wide_d;
    logic       done;
    logic       load;
    logic       accept;
    t_result    result;

    assign load            = done && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !done || load;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    ibfr_assembler u_asm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_start  (i_s_axis_tuser),
        .i_wide   (r_burst_wide),
        .i_load   (load),
        .o_frame  (frame),
        .o_sum    (sum),
        .o_wide   (wide_d),
        .o_done   (done)
    );

    ibfr_decoder #(
        .TEMP_WINDOW (TEMP_WINDOW)
    ) u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_frame  (frame),
        .i_sum    (sum),
        .i_wide   (wide_d),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_wide <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_burst_wide <= i_cfg_data;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_user <= result.status;
            r_out_data <= {7'd0, result.temp_window_sum, result.temp_ready,
                           result.lin_z, result.lin_y, result.lin_x,
                           result.rot_z, result.rot_y, result.rot_x,
                           result.diag_word, result.sample_counter, result.lost_sample};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

// ===== hw/rtl/ibfr_assembler.sv =====
// Byte capture, position tracking and running checksum for one frame.
module ibfr_assembler
    import ibfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    input  logic        i_wide,
    input  logic        i_load,
    output t_frame      o_frame,
    output logic [7:0]  o_sum,
    output logic        o_wide,
    output logic        o_done
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic             r_done;
    logic             r_wide;
    t_frame           r_bytes;

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] len;
    logic [7:0]       sum_base;
    logic             complete;

    always_comb begin
        pos = i_start ? '0 : r_pos;
        if (pos > POS_W'(FRAME_MAX - 1)) begin
            pos = POS_W'(FRAME_MAX - 1);
        end
        len      = i_wide ? POS_W'(WIDE_LEN) : POS_W'(NARROW_LEN);
        sum_base = (pos == '0) ? 8'd0 : r_sum;
        n_sum    = sum_base;
        if (pos >= POS_W'(2) && pos < len - POS_W'(2)) begin
            n_sum = sum_base + i_byte;
        end
        complete = (pos >= len - POS_W'(1));
        n_pos    = complete ? '0 : pos + POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_done <= 1'b0;
            r_wide <= 1'b0;
        end else begin
            if (i_load) begin
                r_done <= 1'b0;
            end
            if (i_accept) begin
                r_pos <= n_pos;
                r_sum <= n_sum;
                if (complete) begin
                    r_done <= 1'b1;
                    r_wide <= i_wide;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_bytes[pos] <= i_byte;
        end
    end

    assign o_frame = r_bytes;
    assign o_sum   = r_sum;
    assign o_wide  = r_wide;
    assign o_done  = r_done;

endmodule

// ===== hw/rtl/ibfr_decoder.sv =====
// Frame decode: duplicate and checksum tests, axes, counter and temperature window.
module ibfr_decoder
    import ibfr_pkg::*;
#(
    parameter int TEMP_WINDOW = TEMP_WINDOW_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_frame     i_frame,
    input  logic [7:0] i_sum,
    input  logic       i_wide,
    output t_result    o_result
);

    logic [15:0]                  r_prev;
    logic                         r_seen;
    logic signed [TEMP_SUM_W-1:0] r_acc, n_acc;
    logic [TEMP_CNT_W-1:0]        r_cnt, n_cnt;

    logic [15:0]                  counter;
    logic [15:0]                  temp_raw;
    logic [7:0]                   check;
    logic                         hit;
    logic signed [31:0]           axis [6];
    logic [15:0]                  w;

    always_comb begin
        counter  = i_wide ? word16(i_frame, WIDE_LEN - 4) : word16(i_frame, NARROW_LEN - 4);
        temp_raw = i_wide ? word16(i_frame, WIDE_LEN - 6) : word16(i_frame, NARROW_LEN - 6);
        check    = i_wide ? i_frame[WIDE_LEN-1] : i_frame[NARROW_LEN-1];
        w        = '0;

        for (int k = 0; k < 6; k++) begin
            if (i_wide) begin
                axis[k] = {word16(i_frame, 4 + 4*k + 2), word16(i_frame, 4 + 4*k)};
                if (k != 0 && k != 3) begin
                    axis[k] = neg_sat(axis[k]);
                end
            end else begin
                w       = word16(i_frame, 4 + 2*k);
                axis[k] = {{16{w[15]}}, w};
            end
        end

        n_acc = r_acc + {{(TEMP_SUM_W-16){temp_raw[15]}}, temp_raw};
        n_cnt = r_cnt + TEMP_CNT_W'(1);
        hit   = (n_cnt == TEMP_CNT_W'(TEMP_WINDOW));

        o_result                 = '0;
        o_result.sample_counter  = counter;
        o_result.diag_word       = word16(i_frame, 2);
        if (counter == r_prev) begin
            o_result.status = STAT_DUP;
        end else if (check != i_sum) begin
            o_result.status = STAT_BAD;
        end else begin
            o_result.status          = STAT_OK;
            o_result.lost_sample     = r_seen && (r_prev + 16'd1 != counter);
            o_result.rot_x           = axis[0];
            o_result.rot_y           = axis[1];
            o_result.rot_z           = axis[2];
            o_result.lin_x           = axis[3];
            o_result.lin_y           = axis[4];
            o_result.lin_z           = axis[5];
            o_result.temp_ready      = hit;
            o_result.temp_window_sum = hit ? n_acc : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_seen <= 1'b0;
            r_acc  <= '0;
            r_cnt  <= '0;
        end else if (i_load && o_result.status == STAT_OK) begin
            r_prev <= counter;
            r_seen <= 1'b1;
            if (hit) begin
                r_acc <= '0;
                r_cnt <= '0;
            end else begin
                r_acc <= n_acc;
                r_cnt <= n_cnt;
            end
        end
    end

endmodule
